>>> rtl/bbsc_pkg.sv
// shared types and constants of the box brush sweep clip block
package bbsc_pkg;
  localparam int MaxSides = 64;
  localparam int FracBits = 16;
  localparam int SideW = $clog2(MaxSides);
  localparam int FracW = FracBits + 1;
  localparam logic [FracW-1:0] FracOne = FracW'(1) << FracBits;
  localparam logic signed [51:0] EpsQ16 = 52'sd2048;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_VEC   = 2'd1,
    REQ_PLANE = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic [1:0] VecStart = 2'd0;
  localparam logic [1:0] VecEnd   = 2'd1;
  localparam logic [1:0] VecMins  = 2'd2;
  localparam logic [1:0] VecMaxs  = 2'd3;
  localparam logic [1:0] AxialNone = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [1:0]        vec_sel;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [31:0] plane_dist;
    logic [1:0]        axial_type;
    logic [2:0]        sign_bits;
    logic              last_side;
    logic [31:0]       brush_contents;
  } in_req_t;

  typedef struct packed {
    logic [FracW-1:0] trace_fraction;
    logic             start_solid;
    logic             all_solid;
    logic [31:0]      hit_contents;
    logic [SideW-1:0] hit_side;
    logic             brush_hit;
  } out_req_t;
endpackage

>>> rtl/bbsc_if.sv
// valid/ready channel interfaces of the box brush sweep clip block
interface bbsc_in_if import bbsc_pkg::*; ();
  logic    valid;
  logic    ready;
  in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bbsc_out_if import bbsc_pkg::*; ();
  logic     valid;
  logic     ready;
  out_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/box_brush_sweep_clip_core.sv
// box brush sweep clip top level: bit-serial dot products and fraction divider
// sequence: a setup request is handled in idle; a plane runs nine products (load, shift-add,
// accumulate), seed and decide steps, then, unless decide ends it, an early-out or a full divide, then finish
// a plane of an already rejected brush goes straight to finish; the last side's result follows
// throughput: one request at a time, set by the single shift-add multiplier
// reset: synchronous active-low rst_n clears vectors, brush and trace state
module box_brush_sweep_clip_core import bbsc_pkg::*; (
  input logic clk,
  input logic rst_n,
  bbsc_in_if.sink    in_ch,
  bbsc_out_if.source out_ch
);
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_DEC, S_DIV, S_FIN} state_t;

  state_t state_r;
  logic signed [31:0] sp_r [3];
  logic signed [31:0] ep_r [3];
  logic signed [31:0] mn_r [3];
  logic signed [31:0] mx_r [3];
  logic [FracW-1:0] enter_r, leave_r, best_r;
  logic no_entry_r;
  logic [SideW-1:0] enter_side_r, side_cnt_r, best_side_r;
  logic startout_r, getout_r, rejected_r;
  logic rs_start_r, rs_all_r;
  logic [31:0] best_cont_r;
  in_req_t req_r;

  // product sequencing: idx 0..2 offset terms, 3 seeds d1/d2, 4..6 start, 7..9 end (x,y,z)
  logic [3:0] pidx_r;
  logic [5:0] bit_r;
  logic [31:0] mplier_r;
  logic signed [65:0] acc_r;
  logic mneg_r;
  logic signed [63:0] mcand_r;
  logic signed [51:0] off_r, d1_r, d2_r;

  // divider
  logic signed [53:0] rem_r;
  logic signed [53:0] den_r;
  logic [FracBits-1:0] q_r;
  logic [4:0] dcnt_r;
  logic dentry_r;

  logic out_valid_r;
  out_req_t out_r;

  logic signed [31:0] n_sel, o_sel, a_sel;
  logic [1:0] axis;
  logic use_prod;
  logic signed [65:0] acc_nxt;
  logic signed [63:0] prod;
  logic signed [51:0] pq;
  logic signed [53:0] rem2;

  always_comb begin
    unique case (pidx_r)
      4'd0, 4'd4, 4'd7: axis = 2'd0;
      4'd1, 4'd5, 4'd8: axis = 2'd1;
      default:          axis = 2'd2;
    endcase
    unique case (axis)
      2'd0: n_sel = req_r.coord_x;
      2'd1: n_sel = req_r.coord_y;
      default: n_sel = req_r.coord_z;
    endcase
    o_sel = req_r.sign_bits[axis] ? mx_r[axis] : mn_r[axis];
    if (pidx_r < 4'd3) begin
      a_sel = o_sel;
      use_prod = (req_r.axial_type == AxialNone) || (req_r.axial_type == axis);
    end else if (pidx_r < 4'd7) begin
      a_sel = sp_r[axis];
      use_prod = 1'b1;
    end else begin
      a_sel = ep_r[axis];
      use_prod = 1'b1;
    end
    acc_nxt = mplier_r[0] ? acc_r + 66'(mcand_r) : acc_r;
    prod = mneg_r ? -acc_r[63:0] : acc_r[63:0];
    pq = 52'(prod >>> 16);
    rem2 = rem_r <<< 1;
  end

  wire in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int j = 0; j < 3; j++) begin
        sp_r[j] <= '0; ep_r[j] <= '0; mn_r[j] <= '0; mx_r[j] <= '0;
      end
      enter_r <= '0; no_entry_r <= 1'b1; leave_r <= FracOne;
      enter_side_r <= '0; side_cnt_r <= '0;
      startout_r <= 1'b0; getout_r <= 1'b0; rejected_r <= 1'b0;
      best_r <= FracOne; rs_start_r <= 1'b0; rs_all_r <= 1'b0;
      best_cont_r <= '0; best_side_r <= '0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            req_r <= in_ch.data;
            unique case (req_t'(in_ch.data.req_type))
              REQ_CLEAR: begin
                best_r <= FracOne; rs_start_r <= 1'b0; rs_all_r <= 1'b0;
                best_cont_r <= '0; best_side_r <= '0;
                enter_r <= '0; no_entry_r <= 1'b1; leave_r <= FracOne;
                enter_side_r <= '0; side_cnt_r <= '0;
                startout_r <= 1'b0; getout_r <= 1'b0; rejected_r <= 1'b0;
              end
              REQ_VEC: begin
                unique case (in_ch.data.vec_sel)
                  VecStart: begin
                    sp_r[0] <= in_ch.data.coord_x; sp_r[1] <= in_ch.data.coord_y;
                    sp_r[2] <= in_ch.data.coord_z;
                  end
                  VecEnd: begin
                    ep_r[0] <= in_ch.data.coord_x; ep_r[1] <= in_ch.data.coord_y;
                    ep_r[2] <= in_ch.data.coord_z;
                  end
                  VecMins: begin
                    mn_r[0] <= in_ch.data.coord_x; mn_r[1] <= in_ch.data.coord_y;
                    mn_r[2] <= in_ch.data.coord_z;
                  end
                  default: begin
                    mx_r[0] <= in_ch.data.coord_x; mx_r[1] <= in_ch.data.coord_y;
                    mx_r[2] <= in_ch.data.coord_z;
                  end
                endcase
              end
              REQ_PLANE: begin
                pidx_r <= '0;
                off_r <= '0;
                state_r <= rejected_r ? S_FIN : S_ACC;
                bit_r <= '0;
              end
              default: ;
            endcase
          end
        end
        S_ACC: begin
          // load one product: magnitudes, sign kept apart
          mneg_r <= a_sel[31] ^ n_sel[31];
          mcand_r <= 64'(a_sel[31] ? -33'(a_sel) : 33'(a_sel));
          mplier_r <= n_sel[31] ? 32'(-33'(n_sel)) : n_sel;
          acc_r <= '0;
          bit_r <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          acc_r <= acc_nxt;
          mcand_r <= mcand_r <<< 1;
          mplier_r <= mplier_r >> 1;
          bit_r <= bit_r + 6'd1;
          if (bit_r == 6'd31) begin
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          if (pidx_r <= 4'd3) begin
            // pidx 3 is the pseudo slot that seeds d1/d2
            if (pidx_r < 4'd3) begin
              if (use_prod) off_r <= off_r + pq;
              pidx_r <= pidx_r + 4'd1;
              state_r <= (pidx_r == 4'd2) ? S_DEC : S_ACC;
              if (pidx_r == 4'd2) pidx_r <= 4'd3;
            end else begin
              d1_r <= off_r - 52'(req_r.plane_dist);
              d2_r <= off_r - 52'(req_r.plane_dist);
              pidx_r <= 4'd4;
              state_r <= S_ACC;
            end
          end else if (pidx_r < 4'd10) begin
            if (pidx_r < 4'd7) d1_r <= d1_r + pq;
            else d2_r <= d2_r + pq;
            pidx_r <= pidx_r + 4'd1;
            state_r <= (pidx_r == 4'd9) ? S_DEC : S_ACC;
            if (pidx_r == 4'd9) pidx_r <= 4'd10;
          end else begin
            // plane decision
            if (d2_r > 0) getout_r <= 1'b1;
            if (d1_r > 0) startout_r <= 1'b1;
            if (d1_r > 0 && (d2_r >= EpsQ16 || d2_r >= d1_r)) begin
              rejected_r <= 1'b1;
              state_r <= S_FIN;
            end else if (d1_r <= 0 && d2_r <= 0) begin
              state_r <= S_FIN;
            end else begin
              dentry_r <= d1_r > d2_r;
              if (d1_r > d2_r) begin
                rem_r <= 54'(d1_r) - 54'(EpsQ16);
                den_r <= 54'(d1_r) - 54'(d2_r);
              end else begin
                rem_r <= -54'(d1_r) - 54'(EpsQ16);
                den_r <= 54'(d2_r) - 54'(d1_r);
              end
              q_r <= '0;
              dcnt_r <= '0;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (dcnt_r == 5'd0 && (rem_r <= 0 || rem_r >= den_r)) begin
            logic [FracW-1:0] f;
            f = (rem_r <= 0) ? '0 : FracOne;
            if (dentry_r) begin
              if (no_entry_r || f > enter_r) begin
                enter_r <= f; enter_side_r <= side_cnt_r; no_entry_r <= 1'b0;
              end
            end else if (f < leave_r) leave_r <= f;
            state_r <= S_FIN;
          end else if (dcnt_r == 5'(FracBits)) begin
            if (dentry_r) begin
              if (no_entry_r || FracW'(q_r) > enter_r) begin
                enter_r <= FracW'(q_r); enter_side_r <= side_cnt_r;
                no_entry_r <= 1'b0;
              end
            end else if (FracW'(q_r) < leave_r) leave_r <= FracW'(q_r);
            state_r <= S_FIN;
          end else begin
            if (rem2 >= den_r) begin
              rem_r <= rem2 - den_r;
              q_r <= {q_r[FracBits-2:0], 1'b1};
            end else begin
              rem_r <= rem2;
              q_r <= {q_r[FracBits-2:0], 1'b0};
            end
            dcnt_r <= dcnt_r + 5'd1;
          end
        end
        S_FIN: begin
          state_r <= S_IDLE;
          if (!req_r.last_side) begin
            if (side_cnt_r != SideW'(MaxSides - 1)) side_cnt_r <= side_cnt_r + SideW'(1);
          end else begin
            logic hit;
            logic [FracW-1:0] bf;
            logic [31:0] bc;
            logic [SideW-1:0] bs;
            logic rs, ra;
            hit = 1'b0; bf = best_r; bc = best_cont_r; bs = best_side_r;
            rs = rs_start_r; ra = rs_all_r;
            if (!rejected_r) begin
              if (!startout_r) begin
                rs = 1'b1;
                if (!getout_r) begin
                  ra = 1'b1; bf = '0; bc = req_r.brush_contents; hit = 1'b1;
                end
              end else if (!no_entry_r && enter_r < leave_r && enter_r < best_r) begin
                bf = enter_r; bc = req_r.brush_contents; bs = enter_side_r;
                hit = 1'b1;
              end
            end
            best_r <= bf; best_cont_r <= bc; best_side_r <= bs;
            rs_start_r <= rs; rs_all_r <= ra;
            out_r <= '{trace_fraction: bf, start_solid: rs, all_solid: ra,
                       hit_contents: bc, hit_side: bs, brush_hit: hit};
            out_valid_r <= 1'b1;
            enter_r <= '0; no_entry_r <= 1'b1; leave_r <= FracOne;
            enter_side_r <= '0; side_cnt_r <= '0;
            startout_r <= 1'b0; getout_r <= 1'b0; rejected_r <= 1'b0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_frac: assert property (@(posedge clk) disable iff (!rst_n)
    best_r <= FracOne && leave_r <= FracOne) else $error("fraction out of range");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ch.ready) else $error("ready while result pending");
  a_allsolid: assert property (@(posedge clk) disable iff (!rst_n)
    rs_all_r |-> rs_start_r && best_r == '0) else $error("all solid inconsistent");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN) else $error("stray result");
endmodule

>>> bench/bbsc_tb_pkg.sv
// helper types for the box brush sweep clip testbench
package bbsc_tb_pkg;
  typedef logic signed [63:0] q_t;
endpackage

>>> bench/box_brush_sweep_clip_core_tb.sv
// testbench of the box brush sweep clip core: directed and random requests against a predictor
module box_brush_sweep_clip_core_tb import bbsc_pkg::*, bbsc_tb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  bbsc_in_if in_ch ();
  bbsc_out_if out_ch ();

  box_brush_sweep_clip_core dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  q_t pt_start [3];
  q_t pt_end [3];
  q_t bx_mins [3];
  q_t bx_maxs [3];
  logic [FracW-1:0] enter_frac, leave_frac, best_frac;
  logic no_entry;
  logic [SideW-1:0] enter_sd, side_cnt, best_sd;
  logic fl_startout, fl_getout, fl_rejected, rs_start, rs_all;
  logic [31:0] best_cont;

  out_req_t hit_queue [$];
  int errors;
  longint cycles;
  int hold_off;
  logic burst_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic q_t mul_q(q_t a, q_t b);
    q_t p;
    p = a * b;
    if (p >= 0) return p >>> 16;
    return -((-p + 65535) >>> 16);
  endfunction

  function automatic logic [FracW-1:0] frac_quot(q_t num, q_t den);
    q_t r;
    logic [FracW-1:0] q;
    r = num;
    q = '0;
    if (num >= den) return FracOne;
    for (int i = 0; i < FracBits; i++) begin
      r = r * 2;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  task automatic clear_brush_state();
    enter_frac = '0;
    no_entry = 1'b1;
    leave_frac = FracOne;
    enter_sd = '0;
    side_cnt = '0;
    {fl_startout, fl_getout, fl_rejected} = '0;
  endtask

  task automatic clear_trace_state();
    best_frac = FracOne;
    {rs_start, rs_all} = '0;
    best_cont = '0;
    best_sd = '0;
  endtask

  task automatic clip_plane(in_req_t r);
    q_t nrm [3];
    q_t off [3];
    q_t offterm, d1, d2, num;
    logic [FracW-1:0] f;
    nrm[0] = r.coord_x;
    nrm[1] = r.coord_y;
    nrm[2] = r.coord_z;
    offterm = 0;
    for (int j = 0; j < 3; j++) off[j] = r.sign_bits[j] ? bx_maxs[j] : bx_mins[j];
    if (r.axial_type != AxialNone) offterm = mul_q(off[r.axial_type], nrm[r.axial_type]);
    else for (int j = 0; j < 3; j++) offterm += mul_q(off[j], nrm[j]);
    d1 = offterm - q_t'(r.plane_dist);
    d2 = d1;
    for (int j = 0; j < 3; j++) begin
      d1 += mul_q(pt_start[j], nrm[j]);
      d2 += mul_q(pt_end[j], nrm[j]);
    end
    if (d2 > 0) fl_getout = 1'b1;
    if (d1 > 0) fl_startout = 1'b1;
    if (d1 > 0 && (d2 >= 2048 || d2 >= d1)) begin
      fl_rejected = 1'b1;
      return;
    end
    if (d1 <= 0 && d2 <= 0) return;
    if (d1 > d2) begin
      num = d1 - 2048;
      f = num > 0 ? frac_quot(num, d1 - d2) : '0;
      if (no_entry || f > enter_frac) begin
        enter_frac = f;
        enter_sd = side_cnt;
        no_entry = 1'b0;
      end
    end else begin
      num = -d1 - 2048;
      f = num > 0 ? frac_quot(num, d2 - d1) : '0;
      if (f < leave_frac) leave_frac = f;
    end
  endtask

  task automatic predict_sweep(in_req_t r);
    out_req_t o;
    logic hit;
    hit = 1'b0;
    case (req_t'(r.req_type))
      REQ_CLEAR: begin
        clear_trace_state();
        clear_brush_state();
      end
      REQ_VEC: begin
        case (r.vec_sel)
          VecStart: pt_start = '{r.coord_x, r.coord_y, r.coord_z};
          VecEnd: pt_end = '{r.coord_x, r.coord_y, r.coord_z};
          VecMins: bx_mins = '{r.coord_x, r.coord_y, r.coord_z};
          default: bx_maxs = '{r.coord_x, r.coord_y, r.coord_z};
        endcase
      end
      REQ_PLANE: begin
        if (!fl_rejected) clip_plane(r);
        if (!r.last_side) begin
          if (side_cnt < MaxSides - 1) side_cnt++;
        end else begin
          if (!fl_rejected) begin
            if (!fl_startout) begin
              rs_start = 1'b1;
              if (!fl_getout) begin
                rs_all = 1'b1;
                best_frac = '0;
                best_cont = r.brush_contents;
                hit = 1'b1;
              end
            end else if (!no_entry && enter_frac < leave_frac && enter_frac < best_frac) begin
              best_frac = enter_frac;
              best_cont = r.brush_contents;
              best_sd = enter_sd;
              hit = 1'b1;
            end
          end
          o.trace_fraction = best_frac;
          o.start_solid = rs_start;
          o.all_solid = rs_all;
          o.hit_contents = best_cont;
          o.hit_side = best_sd;
          o.brush_hit = hit;
          hit_queue.push_back(o);
          clear_brush_state();
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
  endtask

  always @(posedge clk) begin
    out_req_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (hit_queue.size() == 0) report_mismatch("unexpected result", 1, 0);
      else begin
        want = hit_queue.pop_front();
        if (got.trace_fraction !== want.trace_fraction)
          report_mismatch("trace_fraction", got.trace_fraction, want.trace_fraction);
        if (got.start_solid !== want.start_solid)
          report_mismatch("start_solid", got.start_solid, want.start_solid);
        if (got.all_solid !== want.all_solid)
          report_mismatch("all_solid", got.all_solid, want.all_solid);
        if (got.hit_contents !== want.hit_contents)
          report_mismatch("hit_contents", got.hit_contents, want.hit_contents);
        if (got.hit_side !== want.hit_side)
          report_mismatch("hit_side", got.hit_side, want.hit_side);
        if (got.brush_hit !== want.brush_hit)
          report_mismatch("brush_hit", got.brush_hit, want.brush_hit);
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (burst_mode) out_ch.ready <= 1'b1;
    else out_ch.ready <= (cycles % 7 < 4) || ($urandom_range(0, 3) == 0);
  end

  int gap_left, burst_left;

  task automatic send_request(in_req_t r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap_left = burst_mode ? 0 : $urandom_range(0, 6);
    end
    repeat (gap_left) @(negedge clk);
    gap_left = 0;
    burst_left--;
    in_ch.data = r;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_sweep(r);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic in_req_t blank_req();
    in_req_t r;
    r = '0;
    r.axial_type = AxialNone;
    return r;
  endfunction

  task automatic load_vec(logic [1:0] sel, int x, int y, int z);
    in_req_t r;
    r = blank_req();
    r.req_type = REQ_VEC;
    r.vec_sel = sel;
    r.coord_x = x;
    r.coord_y = y;
    r.coord_z = z;
    send_request(r);
  endtask

  task automatic clear_trace();
    in_req_t r;
    r = blank_req();
    r.req_type = REQ_CLEAR;
    send_request(r);
  endtask

  task automatic send_plane(int nx, int ny, int nz, int pdist, logic [1:0] ax,
                            logic [2:0] sb, logic last, logic [31:0] cont);
    in_req_t r;
    r = blank_req();
    r.req_type = REQ_PLANE;
    r.coord_x = nx;
    r.coord_y = ny;
    r.coord_z = nz;
    r.plane_dist = pdist;
    r.axial_type = ax;
    r.sign_bits = sb;
    r.last_side = last;
    r.brush_contents = cont;
    send_request(r);
  endtask

  // axial box brush around center c with half size h, all in units
  task automatic send_box_brush(int c [3], int h, logic [31:0] cont, logic [2:0] corner);
    for (int k = 0; k < 6; k++) begin
      int a, s, n [3];
      a = k / 2;
      s = (k % 2) ? -1 : 1;
      n = '{0, 0, 0};
      n[a] = s * 65536;
      send_plane(n[0], n[1], n[2], (s * c[a] + h) * 65536, 2'(a),
                 s > 0 ? corner : ~corner, k == 5, cont);
    end
  endtask

  task automatic wait_drained();
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_point_trace();
    int c [3];
    clear_trace();
    load_vec(VecStart, -20 * 65536, 0, 0);
    load_vec(VecEnd, 20 * 65536, 65536, 0);
    c = '{0, 0, 0};
    send_box_brush(c, 4, 32'h1, 3'b000);
    c = '{-5, 0, 0};
    send_box_brush(c, 2, 32'h2, 3'b000);
  endtask

  task automatic test_box_and_solid();
    int c [3];
    load_vec(VecMins, -65536, -65536, -65536);
    load_vec(VecMaxs, 65536, 65536, 65536);
    c = '{0, 0, 0};
    send_box_brush(c, 30, 32'hFFFFFFFF, 3'b000);
    load_vec(VecEnd, -20 * 65536, 0, 0);
    send_box_brush(c, 25, 32'h80000000, 3'b101);
  endtask

  task automatic test_position_and_odd();
    int c [3];
    clear_trace();
    load_vec(VecEnd, -20 * 65536, 0, 0);
    c = '{-20, 0, 0};
    send_box_brush(c, 3, 32'h10, 3'b111);
    send_plane(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 2'd0, 3'b010, 1'b1, 32'h4);
    send_plane(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, AxialNone, 3'b111,
               1'b1, 32'h8);
    begin
      in_req_t r;
      r = blank_req();
      r.req_type = REQ_NONE;
      send_request(r);
    end
    load_vec(VecStart, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    load_vec(VecEnd, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
  endtask

  task automatic test_many_sides();
    clear_trace();
    load_vec(VecStart, 0, 0, 10 * 65536);
    load_vec(VecEnd, 0, 0, -10 * 65536);
    for (int k = 0; k < 70; k++)
      send_plane(0, 0, 65536, (k == 66 ? 3 : 1) * 65536, 2'd2, 3'($urandom), 1'b0, 0);
    send_plane(0, 0, -65536, 5 * 65536, 2'd2, 3'b000, 1'b1, 32'h55);
  endtask

  task automatic test_stall_fill();
    int c [3];
    hold_off = 3000;
    c = '{0, 0, 0};
    for (int b = 0; b < 3; b++) send_box_brush(c, 2 + b, 32'h100 << b, 3'b011);
    wait_drained();
  endtask

  task automatic test_random_sweeps(int n_items);
    int sent, c [3], h, roll;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 19);
      burst_mode = ($urandom_range(0, 9) == 0);
      if (roll == 0) begin
        clear_trace();
        sent++;
      end else if (roll < 4) begin
        load_vec(2'($urandom), $urandom_range(0, 60) * 65536 - 30 * 65536 + $urandom_range(0, 65535),
                 $urandom_range(0, 60) * 65536 - 30 * 65536, $urandom_range(0, 8) * 8192 - 32768);
        sent++;
      end else if (roll < 6) begin
        send_plane($urandom, $urandom, $urandom, $urandom, 2'($urandom), 3'($urandom),
                   $urandom_range(0, 1), $urandom);
        sent++;
      end else begin
        c = '{$urandom_range(0, 40) - 20, $urandom_range(0, 10) - 5, $urandom_range(0, 6) - 3};
        h = $urandom_range(1, 8);
        send_box_brush(c, h, $urandom, 3'($urandom));
        sent += 6;
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    hold_off = 0;
    burst_mode = 1'b0;
    gap_left = 0;
    burst_left = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    for (int j = 0; j < 3; j++) begin
      pt_start[j] = 0;
      pt_end[j] = 0;
      bx_mins[j] = 0;
      bx_maxs[j] = 0;
    end
    clear_brush_state();
    clear_trace_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_point_trace();
    test_box_and_solid();
    test_position_and_odd();
    test_many_sides();
    test_stall_fill();
    test_random_sweeps(500);
    wait_drained();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
